FILE: src/dplp_pkg.sv
package dplp_pkg;

  // Default width of the press and long-press counters
  localparam int COUNT_WIDTH_DEF = 16;

  // Register field widths
  localparam int WINDOW_W = 16;
  localparam int BOUNCE_W = 8;
  localparam int HOLD_W   = 16;
  localparam int TOTAL_W  = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_TICKS = 2'd2;

  // Register reset values
  localparam logic [WINDOW_W-1:0] WINDOW_TICKS_RST     = 16'd54000;
  localparam logic [BOUNCE_W-1:0] DEBOUNCE_TICKS_RST   = 8'd54;
  localparam logic [HOLD_W-1:0]   LONG_PRESS_TICKS_RST = 16'd5400;

  // Operation codes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // Button pin is active low
  localparam logic LEVEL_PRESSED  = 1'b0;
  localparam logic LEVEL_RELEASED = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PRESS_DB,
    PH_HOLD,
    PH_RELEASE_DB
  } phase_t;

endpackage

FILE: src/debounced_press_and_long_press_counter.sv
// Debounced press and long-press counter. Each input transaction is either a start command
// (op = 1), which clears both totals and opens a counting window, or one timer tick (op = 0)
// carrying the sampled active-low button level. Every accepted transaction produces exactly one
// result transaction with the totals, the window state after that item, and a done flag on the
// tick that closes the window. The tracker state updates at the accepting clock edge and the
// result is loaded into the output register at that same edge; a new transaction is accepted every cycle
// as long as the output register is empty or being drained, so the sustained rate is one item per
// clock. Configuration writes take effect at the edge they are issued and are meant to happen
// while no transaction is in flight.
module debounced_press_and_long_press_counter #(
  parameter int COUNT_WIDTH = dplp_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_en,
  input  logic [dplp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dplp_pkg::CFG_W-1:0]     cfg_data,
  // input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           op,
  input  logic                           button_level,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [dplp_pkg::TOTAL_W-1:0]   press_total,
  output logic [dplp_pkg::TOTAL_W-1:0]   long_total,
  output logic                           window_active,
  output logic                           window_done
);
  import dplp_pkg::*;

  localparam int CLAMP_W = (COUNT_WIDTH > TOTAL_W) ? COUNT_WIDTH : TOTAL_W;

  // configuration registers
  logic [WINDOW_W-1:0] window_ticks;
  logic [BOUNCE_W-1:0] debounce_ticks;
  logic [HOLD_W-1:0]   long_press_ticks;

  // tracker state
  phase_t                 phase, phase_next;
  logic [WINDOW_W-1:0]    window_count, window_count_next;
  logic [BOUNCE_W-1:0]    bounce_count, bounce_count_next;
  logic [HOLD_W-1:0]      hold_count, hold_count_next;
  logic [COUNT_WIDTH-1:0] press_count, press_count_next;
  logic [COUNT_WIDTH-1:0] long_count, long_count_next;
  logic                   active, active_next;
  logic                   done_next;

  logic                   in_fire;
  logic [WINDOW_W-1:0]    window_inc;
  logic [BOUNCE_W-1:0]    bounce_inc;
  logic [HOLD_W-1:0]      hold_inc;
  logic [COUNT_WIDTH-1:0] press_inc, long_inc;
  logic [CLAMP_W-1:0]     press_wide, long_wide;

  // Accept whenever the result register is free or draining
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks     <= WINDOW_TICKS_RST;
      debounce_ticks   <= DEBOUNCE_TICKS_RST;
      long_press_ticks <= LONG_PRESS_TICKS_RST;
    end else if (cfg_en) begin
      case (cfg_index)
        CFG_WINDOW_TICKS:     window_ticks     <= cfg_data[WINDOW_W-1:0];
        CFG_DEBOUNCE_TICKS:   debounce_ticks   <= cfg_data[BOUNCE_W-1:0];
        CFG_LONG_PRESS_TICKS: long_press_ticks <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturating increments
  assign window_inc = (window_count != '1) ? window_count + WINDOW_W'(1) : window_count;
  assign bounce_inc = (bounce_count != '1) ? bounce_count + BOUNCE_W'(1) : bounce_count;
  assign hold_inc   = (hold_count != '1) ? hold_count + HOLD_W'(1) : hold_count;
  assign press_inc  = (press_count != '1) ? press_count + COUNT_WIDTH'(1) : press_count;
  assign long_inc   = (long_count != '1) ? long_count + COUNT_WIDTH'(1) : long_count;

  // Next state of the press tracker for one transaction
  always_comb begin
    phase_next        = phase;
    window_count_next = window_count;
    bounce_count_next = bounce_count;
    hold_count_next   = hold_count;
    press_count_next  = press_count;
    long_count_next   = long_count;
    active_next       = active;
    done_next         = 1'b0;
    if (in_fire) begin
      if (op == OP_START) begin
        phase_next        = PH_IDLE;
        window_count_next = '0;
        bounce_count_next = '0;
        hold_count_next   = '0;
        press_count_next  = '0;
        long_count_next   = '0;
        active_next       = 1'b1;
      end else if (active) begin
        window_count_next = window_inc;
        unique case (phase)
          PH_IDLE: begin
            if (window_inc >= window_ticks) begin
              active_next = 1'b0;
              done_next   = 1'b1;
            end else if (button_level == LEVEL_PRESSED) begin
              phase_next        = PH_PRESS_DB;
              bounce_count_next = '0;
            end
          end
          PH_PRESS_DB: begin
            bounce_count_next = bounce_inc;
            if (bounce_inc >= debounce_ticks) begin
              phase_next      = PH_HOLD;
              hold_count_next = '0;
            end
          end
          PH_HOLD: begin
            if (button_level == LEVEL_RELEASED) begin
              press_count_next  = press_inc;
              bounce_count_next = '0;
              phase_next        = PH_RELEASE_DB;
            end else begin
              hold_count_next = hold_inc;
            end
          end
          PH_RELEASE_DB: begin
            bounce_count_next = bounce_inc;
            if (bounce_inc >= debounce_ticks) begin
              if (hold_count > long_press_ticks) begin
                long_count_next = long_inc;
              end
              phase_next = PH_IDLE;
            end
          end
        endcase
      end
    end
  end

  // Hold tracker state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      window_count <= '0;
      bounce_count <= '0;
      hold_count   <= '0;
      press_count  <= '0;
      long_count   <= '0;
      active       <= 1'b0;
    end else begin
      phase        <= phase_next;
      window_count <= window_count_next;
      bounce_count <= bounce_count_next;
      hold_count   <= hold_count_next;
      press_count  <= press_count_next;
      long_count   <= long_count_next;
      active       <= active_next;
    end
  end

  // Clamp the totals to the report width
  assign press_wide = CLAMP_W'(press_count_next);
  assign long_wide  = CLAMP_W'(long_count_next);

  // Result register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Load result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      press_total   <= (press_wide > CLAMP_W'({TOTAL_W{1'b1}})) ? '1 : press_wide[TOTAL_W-1:0];
      long_total    <= (long_wide > CLAMP_W'({TOTAL_W{1'b1}})) ? '1 : long_wide[TOTAL_W-1:0];
      window_active <= active_next;
      window_done   <= done_next;
    end
  end

  // The window closes only from the idle phase
  a_phase_needs_window: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_IDLE) |-> active)
    else $error("press tracker busy while window closed");

  // Long presses are a subset of completed presses
  a_long_within_press: assert property (@(posedge clk) disable iff (rst)
    long_count <= press_count)
    else $error("long-press count exceeds press count");

  // A done result always reports a closed window
  a_done_closes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && window_done) |-> !window_active)
    else $error("window done reported with window still open");

  // A start yields an open window with cleared totals
  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    (in_fire && op == OP_START) |=>
      (out_valid && window_active && !window_done && press_total == '0 && long_total == '0))
    else $error("start did not clear the totals");

  // A tick with the window closed changes no count
  a_closed_tick_quiet: assert property (@(posedge clk) disable iff (rst)
    (in_fire && op == OP_TICK && !active) |=>
      ($stable(press_count) && $stable(long_count) && !active && !window_done))
    else $error("tick changed state while window closed");

endmodule
